FILE: rtl/core/afc_pkg.sv
package afc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int COORD_W     = 24;
  localparam int SUM_W       = COORD_W + 1;
  localparam int NRM_W       = 14;
  localparam int OFS_W       = 22;
  localparam int OFS_SHIFT   = 13;
  localparam int PLANE_W     = 64;
  localparam int IDX_W       = 3;
  localparam int PROD_W      = SUM_W + NRM_W + 1;
  localparam int ACC_W       = PROD_W + 2;
  localparam int LATENCY     = 1 + 2 * PLANE_COUNT;

  localparam int NX_LSB  = 0;
  localparam int NY_LSB  = 14;
  localparam int NZ_LSB  = 28;
  localparam int OFS_LSB = 42;

  typedef struct packed {
    logic                    vld;
    logic                    vis;
    logic signed [SUM_W-1:0] c2_x;
    logic signed [SUM_W-1:0] c2_y;
    logic signed [SUM_W-1:0] c2_z;
    logic signed [SUM_W-1:0] e2_x;
    logic signed [SUM_W-1:0] e2_y;
    logic signed [SUM_W-1:0] e2_z;
  } afc_beat_t;

endpackage

FILE: rtl/core/afc_front.sv
module afc_front
  import afc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic signed [COORD_W-1:0] min_x,
  input  logic signed [COORD_W-1:0] min_y,
  input  logic signed [COORD_W-1:0] min_z,
  input  logic signed [COORD_W-1:0] max_x,
  input  logic signed [COORD_W-1:0] max_y,
  input  logic signed [COORD_W-1:0] max_z,
  output afc_beat_t                 beat
);

  afc_beat_t beat_r;
  afc_beat_t beat_nxt;

  // doubled center and doubled extent per axis
  always_comb begin
    beat_nxt      = beat_r;
    beat_nxt.vld  = accept;
    beat_nxt.vis  = 1'b1;
    beat_nxt.c2_x = SUM_W'(min_x) + SUM_W'(max_x);
    beat_nxt.c2_y = SUM_W'(min_y) + SUM_W'(max_y);
    beat_nxt.c2_z = SUM_W'(min_z) + SUM_W'(max_z);
    beat_nxt.e2_x = SUM_W'(max_x) - SUM_W'(min_x);
    beat_nxt.e2_y = SUM_W'(max_y) - SUM_W'(min_y);
    beat_nxt.e2_z = SUM_W'(max_z) - SUM_W'(min_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign beat = beat_r;

endmodule

FILE: rtl/core/afc_cell.sv
module afc_cell
  import afc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [PLANE_W-1:0] wr_data,
  input  afc_beat_t          beat_in,
  output afc_beat_t          beat_out
);

  logic [PLANE_W-1:0] plane_r;

  logic signed [NRM_W-1:0]  nx, ny, nz;
  logic signed [NRM_W:0]    ax, ay, az;
  logic signed [OFS_W-1:0]  ofs;

  afc_beat_t a_beat_r;
  logic signed [PROD_W-1:0] pr_x_r, pr_y_r, pr_z_r;
  logic signed [PROD_W-1:0] ps_x_r, ps_y_r, ps_z_r;
  logic signed [PROD_W-1:0] pr_x_nxt, pr_y_nxt, pr_z_nxt;
  logic signed [PROD_W-1:0] ps_x_nxt, ps_y_nxt, ps_z_nxt;

  afc_beat_t b_beat_r;
  afc_beat_t b_beat_nxt;
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (wr_en) begin
      plane_r <= wr_data;
    end
  end

  assign nx  = $signed(plane_r[NX_LSB +: NRM_W]);
  assign ny  = $signed(plane_r[NY_LSB +: NRM_W]);
  assign nz  = $signed(plane_r[NZ_LSB +: NRM_W]);
  assign ofs = $signed(plane_r[OFS_LSB +: OFS_W]);

  assign ax = nx[NRM_W-1] ? -(NRM_W+1)'(nx) : (NRM_W+1)'(nx);
  assign ay = ny[NRM_W-1] ? -(NRM_W+1)'(ny) : (NRM_W+1)'(ny);
  assign az = nz[NRM_W-1] ? -(NRM_W+1)'(nz) : (NRM_W+1)'(nz);

  // stage a: products
  always_comb begin
    pr_x_nxt = PROD_W'($signed(beat_in.e2_x)) * PROD_W'(ax);
    pr_y_nxt = PROD_W'($signed(beat_in.e2_y)) * PROD_W'(ay);
    pr_z_nxt = PROD_W'($signed(beat_in.e2_z)) * PROD_W'(az);
    ps_x_nxt = PROD_W'($signed(beat_in.c2_x)) * PROD_W'(nx);
    ps_y_nxt = PROD_W'($signed(beat_in.c2_y)) * PROD_W'(ny);
    ps_z_nxt = PROD_W'($signed(beat_in.c2_z)) * PROD_W'(nz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_beat_r <= '0;
    end else begin
      a_beat_r <= beat_in;
    end
    pr_x_r   <= pr_x_nxt;
    pr_y_r   <= pr_y_nxt;
    pr_z_r   <= pr_z_nxt;
    ps_x_r   <= ps_x_nxt;
    ps_y_r   <= ps_y_nxt;
    ps_z_r   <= ps_z_nxt;
  end

  // stage b: s + r < 0 means box lies fully outside
  always_comb begin
    acc = ACC_W'(pr_x_r) + ACC_W'(pr_y_r) + ACC_W'(pr_z_r)
        + ACC_W'(ps_x_r) + ACC_W'(ps_y_r) + ACC_W'(ps_z_r)
        + (ACC_W'(ofs) <<< OFS_SHIFT);
    b_beat_nxt     = a_beat_r;
    b_beat_nxt.vis = a_beat_r.vis & ~acc[ACC_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_beat_r <= '0;
    end else begin
      b_beat_r <= b_beat_nxt;
    end
  end

  assign beat_out = b_beat_r;

endmodule

FILE: rtl/core/aabb_frustum_cull_test_top.sv
// Box-versus-frustum cull test. One box (min/max corners, signed Q16.8) is
// taken on every clock where start is high; busy is always low. The box runs
// through a front register and six plane cells, two register stages each;
// out_valid pulses for one cycle with out_visible once the box leaves the
// last cell, one result per box, in order. The receiver cannot stall: the
// result must be captured in that cycle. The user must write planes through
// cfg_we/cfg_index/cfg_data only while no box is in flight (not enforced);
// indexes 0..5 select right, left, bottom, top, far, near; others ignored.
module aabb_frustum_cull_test_top
  import afc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_min_x,
  input  logic signed [COORD_W-1:0] in_min_y,
  input  logic signed [COORD_W-1:0] in_min_z,
  input  logic signed [COORD_W-1:0] in_max_x,
  input  logic signed [COORD_W-1:0] in_max_y,
  input  logic signed [COORD_W-1:0] in_max_z,
  output logic                      out_valid,
  output logic                      out_visible,
  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [PLANE_W-1:0]        cfg_data
);

  afc_beat_t chain [PLANE_COUNT+1];

  assign busy = 1'b0;

  afc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (start & ~busy),
    .min_x  (in_min_x),
    .min_y  (in_min_y),
    .min_z  (in_min_z),
    .max_x  (in_max_x),
    .max_y  (in_max_y),
    .max_z  (in_max_z),
    .beat   (chain[0])
  );

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    afc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (cfg_we && (cfg_index == IDX_W'(i))),
      .wr_data  (cfg_data),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  assign out_valid   = chain[PLANE_COUNT].vld;
  assign out_visible = chain[PLANE_COUNT].vis;

endmodule

FILE: rtl/core/afc_checker.sv
module afc_checker
  import afc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted beat lost");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result without beat");

endmodule

bind aabb_frustum_cull_test_top afc_checker u_afc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import afc_pkg::*;

  localparam int CMIN        = -(1 << (COORD_W - 1));
  localparam int CMAX        = (1 << (COORD_W - 1)) - 1;
  localparam int UNIT        = 256;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                      hold;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_min_x = '0;
  logic signed [COORD_W-1:0] in_min_y = '0;
  logic signed [COORD_W-1:0] in_min_z = '0;
  logic signed [COORD_W-1:0] in_max_x = '0;
  logic signed [COORD_W-1:0] in_max_y = '0;
  logic signed [COORD_W-1:0] in_max_z = '0;
  logic                      out_valid;
  logic                      out_visible;
  logic                      cfg_we = 1'b0;
  logic [IDX_W-1:0]          cfg_index = '0;
  logic [PLANE_W-1:0]        cfg_data = '0;

  logic [PLANE_W-1:0] plane_regs [PLANE_COUNT];
  box_t               boxes_to_send [$];
  bit                 expected_visible [$];
  box_t               cur_box;
  bit                 want_visible;
  int                 send_idle_pct = 8;
  int                 errors = 0;
  int                 cycle_count = 0;

  aabb_frustum_cull_test_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_min_x   (in_min_x),
    .in_min_y   (in_min_y),
    .in_min_z   (in_min_z),
    .in_max_x   (in_max_x),
    .in_max_y   (in_max_y),
    .in_max_z   (in_max_z),
    .out_valid  (out_valid),
    .out_visible(out_visible),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit box_in_frustum(box_t b);
    longint             c2 [3];
    longint             e2 [3];
    longint             nrm [3];
    longint             center_dist;
    longint             radius;
    logic [PLANE_W-1:0] w;
    bit                 vis;
    c2[0] = longint'(b.min_x) + longint'(b.max_x);
    c2[1] = longint'(b.min_y) + longint'(b.max_y);
    c2[2] = longint'(b.min_z) + longint'(b.max_z);
    e2[0] = longint'(b.max_x) - longint'(b.min_x);
    e2[1] = longint'(b.max_y) - longint'(b.min_y);
    e2[2] = longint'(b.max_z) - longint'(b.min_z);
    vis = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      w = plane_regs[p];
      nrm[0] = longint'($signed(w[NX_LSB +: NRM_W]));
      nrm[1] = longint'($signed(w[NY_LSB +: NRM_W]));
      nrm[2] = longint'($signed(w[NZ_LSB +: NRM_W]));
      center_dist = longint'($signed(w[OFS_LSB +: OFS_W])) * (longint'(1) << OFS_SHIFT);
      radius = 0;
      for (int a = 0; a < 3; a++) begin
        radius      += e2[a] * (nrm[a] < 0 ? -nrm[a] : nrm[a]);
        center_dist += c2[a] * nrm[a];
      end
      if (center_dist < -radius) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic int srand(int mag);
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int ofs);
    return {OFS_W'(ofs), NRM_W'(nz), NRM_W'(ny), NRM_W'(nx)};
  endfunction

  function automatic logic [PLANE_W-1:0] random_plane();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 30) return {$urandom, $urandom};
    return pack_plane(srand(4096), srand(4096), srand(4096), srand(1 << $urandom_range(8, 21)));
  endfunction

  function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz, bit hd);
    box_t b;
    b.hold  = hd;
    b.min_x = COORD_W'(lx);
    b.min_y = COORD_W'(ly);
    b.min_z = COORD_W'(lz);
    b.max_x = COORD_W'(hx);
    b.max_y = COORD_W'(hy);
    b.max_z = COORD_W'(hz);
    return b;
  endfunction

  // mostly proper boxes at random scale; some with swapped corners, some raw noise
  function automatic box_t random_box();
    int lo [3];
    int hi [3];
    int ctr;
    int ext;
    int kind;
    int sc;
    int t;
    kind = $urandom_range(99);
    sc   = $urandom_range(8, 21);
    for (int a = 0; a < 3; a++) begin
      ctr   = srand(1 << sc);
      ext   = $urandom_range(1 << $urandom_range(4, 20));
      lo[a] = ctr - ext;
      hi[a] = ctr + ext;
      if (kind >= 80 && kind < 90 && (a == 0 || $urandom_range(1) == 1)) begin
        t     = lo[a];
        lo[a] = hi[a];
        hi[a] = t;
      end
      if (kind >= 90) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(99) < 3);
  endfunction

  task automatic write_reg(int idx, logic [PLANE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= IDX_W'(idx);
    cfg_data  <= val;
    if (idx < PLANE_COUNT) plane_regs[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    while (boxes_to_send.size() != 0 || start) @(negedge clk);
    while (expected_visible.size() != 0 && waited < 4 * LATENCY) begin
      @(negedge clk);
      waited++;
    end
    if (expected_visible.size() != 0) begin
      $error("%0d results never arrived", expected_visible.size());
      errors += expected_visible.size();
      expected_visible.delete();
    end
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // driver: one box per beat; a held box waits until every result is in
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_visible.push_back(box_in_frustum(cur_box));
      if (!start || !busy) begin
        if (boxes_to_send.size() != 0 &&
            !(boxes_to_send[0].hold && (expected_visible.size() != 0 || out_valid)) &&
            $urandom_range(99) >= send_idle_pct) begin
          cur_box = boxes_to_send.pop_front();
          start    <= 1'b1;
          in_min_x <= cur_box.min_x;
          in_min_y <= cur_box.min_y;
          in_min_z <= cur_box.min_z;
          in_max_x <= cur_box.max_x;
          in_max_y <= cur_box.max_y;
          in_max_z <= cur_box.max_z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_visible.size() == 0) begin
        $error("result beat with none expected: visible=%b", out_visible);
        errors++;
      end else begin
        want_visible = expected_visible.pop_front();
        if (out_visible !== want_visible) begin
          $error("visible: expected %b, got %b", want_visible, out_visible);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [PLANE_W-1:0] extreme [3];
    int                 d10;
    for (int p = 0; p < PLANE_COUNT; p++) plane_regs[p] = '0;
    extreme[0] = '1;
    extreme[1] = pack_plane(-8192, -8192, -8192, -(1 << 21));
    extreme[2] = pack_plane(8191, 8191, 8191, (1 << 21) - 1);
    d10 = 10 * UNIT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // planes at reset value: everything visible
    boxes_to_send.push_back(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0));
    boxes_to_send.push_back(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0));
    boxes_to_send.push_back(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
    boxes_to_send.push_back(mk_box(0, 0, 0, 0, 0, 0, 0));
    boxes_to_send.push_back(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0));
    drain();

    for (int k = 0; k < 3; k++) begin
      for (int p = 0; p < PLANE_COUNT; p++) write_reg(p, extreme[k]);
      boxes_to_send.push_back(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
      boxes_to_send.push_back(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0));
      boxes_to_send.push_back(mk_box(0, 0, 0, 0, 0, 0, 0));
      drain();
    end

    // axis-aligned cube of half-size 10; writes past the last plane are dropped
    write_reg(0, pack_plane(-4096, 0, 0, d10));
    write_reg(1, pack_plane(4096, 0, 0, d10));
    write_reg(2, pack_plane(0, 4096, 0, d10));
    write_reg(3, pack_plane(0, -4096, 0, d10));
    write_reg(4, pack_plane(0, 0, -4096, d10));
    write_reg(5, pack_plane(0, 0, 4096, d10));
    write_reg(6, '1);
    write_reg(7, {$urandom, $urandom});
    boxes_to_send.push_back(mk_box(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT, 0));
    boxes_to_send.push_back(mk_box(20 * UNIT, 0, 0, 30 * UNIT, UNIT, UNIT, 0));
    boxes_to_send.push_back(mk_box(5 * UNIT, 0, 0, 30 * UNIT, UNIT, UNIT, 0));
    boxes_to_send.push_back(mk_box(-30 * UNIT, 0, 0, -20 * UNIT, UNIT, UNIT, 0));
    boxes_to_send.push_back(mk_box(0, 20 * UNIT, 0, UNIT, 30 * UNIT, UNIT, 0));
    boxes_to_send.push_back(mk_box(0, -30 * UNIT, 0, UNIT, -20 * UNIT, UNIT, 0));
    boxes_to_send.push_back(mk_box(0, 0, 20 * UNIT, UNIT, UNIT, 30 * UNIT, 0));
    boxes_to_send.push_back(mk_box(0, 0, -30 * UNIT, UNIT, UNIT, -20 * UNIT, 0));
    boxes_to_send.push_back(mk_box(30 * UNIT, 0, 0, 20 * UNIT, UNIT, UNIT, 1));
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 63 : 0;
      for (int p = 0; p < PLANE_COUNT; p++) write_reg(p, random_plane());
      if ($urandom_range(1) == 1) write_reg(6 + $urandom_range(1), {$urandom, $urandom});
      for (int i = 0; i < 105; i++) boxes_to_send.push_back(random_box());
      drain();
    end

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
